// ===== sv/fuhc_pkg.sv =====
package fuhc_pkg;

  // Bus operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Port indexes
  localparam logic [1:0] PORT_DATA   = 2'd0;
  localparam logic [1:0] PORT_CMD    = 2'd1;
  localparam logic [1:0] PORT_STATUS = 2'd2;
  localparam logic [1:0] PORT_BITSEL = 2'd3;

  // Command bytes
  localparam logic [7:0] CMD_WAIT      = 8'hff;
  localparam logic [7:0] CMD_WRITE     = 8'h01;
  localparam logic [7:0] CMD_READ      = 8'h02;
  localparam logic [7:0] CMD_SEND      = 8'h03;
  localparam logic [7:0] CMD_RESULT    = 8'h06;
  localparam logic [7:0] CMD_STATUS    = 8'h07;

  // Return byte values
  localparam logic [7:0] RET_RESET     = 8'hff;
  localparam logic [7:0] RET_RESULT_OK = 8'h40;
  localparam logic [7:0] RET_STATUS_OR = 8'h0a;

  // Fixed upper bits of the status byte
  localparam logic [4:0] STATUS_HIGH   = 5'b11111;

  // Port 3 flag selectors
  localparam logic [2:0] SEL_ATN = 3'd7;
  localparam logic [2:0] SEL_DAC = 3'd6;
  localparam logic [2:0] SEL_RFD = 3'd5;
  localparam logic [2:0] SEL_DAV = 3'd4;

  // Sequencer steps
  typedef enum logic [2:0] {
    STEP_IDLE   = 3'd0,
    STEP_COUNT  = 3'd1,
    STEP_DRIVE  = 3'd2,
    STEP_TRACK  = 3'd3,
    STEP_SECTOR = 3'd4,
    STEP_PUT    = 3'd5,
    STEP_GET    = 3'd6
  } step_t;

endpackage

// ===== sv/floppy_unit_handshake_controller_top.sv =====
// Floppy unit handshake controller. Each accepted transfer is one bus access
// (read or write to ports 0..3) and yields exactly one result transfer in the
// following cycle: the read byte plus seek, put and get requests for the disk
// side. One access is taken every cycle while in_ready is high; the only
// limit is the single output register, so in_ready drops only while a result
// is held and out_ready is low. Port 2 reads run the ATN/DAC/RFD/DAV
// handshake, port 1 writes drive the command sequencer (block count, drive,
// track, sector), and port 0 reads in send mode consume the disk_byte that
// travels with the access. A block count of 0 means 65536 bytes.
module floppy_unit_handshake_controller_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [1:0] port,
  input  logic [7:0] wdata,
  input  logic [7:0] disk_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] rdata,
  output logic       seek_request,
  output logic [7:0] seek_drive,
  output logic [8:0] seek_track,
  output logic [7:0] seek_sector,
  output logic       put_request,
  output logic [7:0] put_byte,
  output logic       get_request
);

  // Controller state
  logic               atn_flag, dac_flag, rfd_flag, dav_flag;
  logic [7:0]         current_command;
  fuhc_pkg::step_t    sequence_step;
  logic [7:0]         drive_number, track_number, sector_number;
  logic [15:0]        bytes_remaining;
  logic [7:0]         return_byte, port1_latch, port3_latch;
  logic               status_dav, previous_dav;

  logic               atn_flag_next, dac_flag_next, rfd_flag_next, dav_flag_next;
  logic [7:0]         current_command_next;
  fuhc_pkg::step_t    sequence_step_next;
  logic [7:0]         drive_number_next, track_number_next, sector_number_next;
  logic [15:0]        bytes_remaining_next;
  logic [7:0]         return_byte_next, port1_latch_next, port3_latch_next;
  logic               status_dav_next, previous_dav_next;

  // Result values before the output register
  logic [7:0]         rd;
  logic               seek, put, get;
  logic [7:0]         pbyte;

  logic               accept;
  logic [15:0]        bytes_dec;
  logic [7:0]         status_byte;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign bytes_dec = bytes_remaining - 16'd1;

  // Access decode and state update
  always_comb begin
    atn_flag_next        = atn_flag;
    dac_flag_next        = dac_flag;
    rfd_flag_next        = rfd_flag;
    dav_flag_next        = dav_flag;
    current_command_next = current_command;
    sequence_step_next   = sequence_step;
    drive_number_next    = drive_number;
    track_number_next    = track_number;
    sector_number_next   = sector_number;
    bytes_remaining_next = bytes_remaining;
    return_byte_next     = return_byte;
    port1_latch_next     = port1_latch;
    port3_latch_next     = port3_latch;
    status_dav_next      = status_dav;
    previous_dav_next    = previous_dav;
    rd    = 8'd0;
    seek  = 1'b0;
    put   = 1'b0;
    get   = 1'b0;
    pbyte = 8'd0;
    status_byte = 8'd0;

    if (operation == fuhc_pkg::OP_READ) begin
      case (port)
        fuhc_pkg::PORT_DATA: begin
          if (dav_flag) begin
            if (sequence_step == fuhc_pkg::STEP_GET) begin
              return_byte_next     = disk_byte;
              get                  = 1'b1;
              bytes_remaining_next = bytes_dec;
              if (bytes_dec == 16'd0) sequence_step_next = fuhc_pkg::STEP_IDLE;
            end
            dac_flag_next = 1'b1;
            rd            = return_byte_next;
          end else begin
            rd = 8'hff;
          end
        end
        fuhc_pkg::PORT_CMD: begin
          rd = port1_latch;
        end
        fuhc_pkg::PORT_STATUS: begin
          // handshake evaluation, first matching rule wins
          if ((previous_dav ^ dav_flag) || (rfd_flag && dav_flag)) begin
            dac_flag_next = dav_flag;
          end else if (atn_flag) begin
            rfd_flag_next        = 1'b1;
            current_command_next = fuhc_pkg::CMD_WAIT;
          end else if (dac_flag) begin
            dav_flag_next = 1'b0;
          end else if (rfd_flag) begin
            dav_flag_next = 1'b1;
          end
          previous_dav_next = status_dav;
          status_dav_next   = dav_flag_next;
          status_byte = {fuhc_pkg::STATUS_HIGH, dac_flag_next, rfd_flag_next, dav_flag_next};
          rd          = status_byte;
        end
        default: begin
          rd = port3_latch;
        end
      endcase
    end else begin
      case (port)
        fuhc_pkg::PORT_CMD: begin
          port1_latch_next = wdata;
          if (current_command == fuhc_pkg::CMD_WAIT) begin
            current_command_next = wdata;
            case (wdata) inside
              fuhc_pkg::CMD_WRITE, fuhc_pkg::CMD_READ:
                sequence_step_next = fuhc_pkg::STEP_COUNT;
              fuhc_pkg::CMD_SEND:
                sequence_step_next = fuhc_pkg::STEP_GET;
              fuhc_pkg::CMD_RESULT:
                return_byte_next = fuhc_pkg::RET_RESULT_OK;
              fuhc_pkg::CMD_STATUS:
                return_byte_next = return_byte | fuhc_pkg::RET_STATUS_OR;
              default: ;
            endcase
          end else if (current_command == fuhc_pkg::CMD_WRITE ||
                       current_command == fuhc_pkg::CMD_READ) begin
            case (sequence_step)
              fuhc_pkg::STEP_COUNT: begin
                bytes_remaining_next = {wdata, 8'd0};
                sequence_step_next   = fuhc_pkg::STEP_DRIVE;
              end
              fuhc_pkg::STEP_DRIVE: begin
                drive_number_next  = wdata;
                sequence_step_next = fuhc_pkg::STEP_TRACK;
              end
              fuhc_pkg::STEP_TRACK: begin
                track_number_next  = wdata;
                sequence_step_next = fuhc_pkg::STEP_SECTOR;
              end
              fuhc_pkg::STEP_SECTOR: begin
                sector_number_next = wdata;
                seek               = 1'b1;
                sequence_step_next = (current_command == fuhc_pkg::CMD_WRITE) ?
                                     fuhc_pkg::STEP_PUT : fuhc_pkg::STEP_IDLE;
              end
              fuhc_pkg::STEP_PUT: begin
                if (current_command == fuhc_pkg::CMD_WRITE) begin
                  put                  = 1'b1;
                  pbyte                = wdata;
                  bytes_remaining_next = bytes_dec;
                  if (bytes_dec == 16'd0) sequence_step_next = fuhc_pkg::STEP_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        fuhc_pkg::PORT_STATUS: begin
          atn_flag_next   = wdata[7];
          dac_flag_next   = wdata[6];
          rfd_flag_next   = wdata[5];
          dav_flag_next   = wdata[4];
          status_dav_next = wdata[4];
        end
        fuhc_pkg::PORT_BITSEL: begin
          port3_latch_next = wdata;
          if (!wdata[7]) begin
            case (wdata[3:1])
              fuhc_pkg::SEL_ATN: atn_flag_next = wdata[0];
              fuhc_pkg::SEL_DAC: dac_flag_next = wdata[0];
              fuhc_pkg::SEL_RFD: rfd_flag_next = wdata[0];
              fuhc_pkg::SEL_DAV: dav_flag_next = wdata[0];
              default: ;
            endcase
            status_dav_next = dav_flag_next;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      atn_flag        <= 1'b0;
      dac_flag        <= 1'b0;
      rfd_flag        <= 1'b0;
      dav_flag        <= 1'b0;
      current_command <= fuhc_pkg::CMD_WAIT;
      sequence_step   <= fuhc_pkg::STEP_IDLE;
      drive_number    <= 8'd0;
      track_number    <= 8'd0;
      sector_number   <= 8'd0;
      bytes_remaining <= 16'd0;
      return_byte     <= fuhc_pkg::RET_RESET;
      port1_latch     <= 8'd0;
      port3_latch     <= 8'd0;
      status_dav      <= 1'b0;
      previous_dav    <= 1'b0;
    end else if (accept) begin
      atn_flag        <= atn_flag_next;
      dac_flag        <= dac_flag_next;
      rfd_flag        <= rfd_flag_next;
      dav_flag        <= dav_flag_next;
      current_command <= current_command_next;
      sequence_step   <= sequence_step_next;
      drive_number    <= drive_number_next;
      track_number    <= track_number_next;
      sector_number   <= sector_number_next;
      bytes_remaining <= bytes_remaining_next;
      return_byte     <= return_byte_next;
      port1_latch     <= port1_latch_next;
      port3_latch     <= port3_latch_next;
      status_dav      <= status_dav_next;
      previous_dav    <= previous_dav_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata        <= rd;
      seek_request <= seek;
      seek_drive   <= (seek || put || get) ? drive_number_next : 8'd0;
      seek_track   <= seek ? {track_number_next, 1'b0} : 9'd0;
      seek_sector  <= seek ? sector_number_next : 8'd0;
      put_request  <= put;
      put_byte     <= pbyte;
      get_request  <= get;
    end
  end

endmodule
